[rtl/plic_pkg.sv]
// plic_pkg: widths, register indexes and sequencer states of the leaky pid controller
// no dependencies; used by the channel interfaces and by pid_leaky_integral_clamp

package plic_pkg;

	// field widths
	localparam int TGT_W      = 16;
	localparam int ERR_W      = TGT_W + 1;
	localparam int GAIN_W     = 16;
	localparam int LIMIT_W    = 31;
	localparam int LEAK_W     = 16;
	localparam int ACC_W      = 40;
	localparam int DRIVE_W    = 32;
	localparam int FRAC_W     = 8;
	localparam int LEAK_FRAC  = 15;

	// configuration channel
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 31;

	// serial step counts
	localparam int MUL_STEPS  = GAIN_W;
	localparam int DIV_STEPS  = LIMIT_W + FRAC_W;
	localparam int CNT_W      = 6;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROP_GAIN   = 3'd0,
		REG_INTEG_GAIN  = 3'd1,
		REG_DERIV_GAIN  = 3'd2,
		REG_INTEG_LIMIT = 3'd3,
		REG_LEAK_FACTOR = 3'd4
	} reg_idx_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_LEAK,
		ST_LEAK_FIX,
		ST_MUL_INTEG,
		ST_CLAMP,
		ST_SUM,
		ST_DIV,
		ST_DIV_FIX
	} state_t;

endpackage

[rtl/plic_ifs.sv]
// plic_ifs: valid/ready channels of the leaky pid controller (step, result, configuration)
// depends on plic_pkg

interface plic_in_if;
	import plic_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [TGT_W-1:0]  target;
	logic signed [TGT_W-1:0]  measured;
	modport source (output valid, target, measured, input ready);
	modport sink   (input valid, target, measured, output ready);
endinterface

interface plic_out_if;
	import plic_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [DRIVE_W-1:0] drive;
	logic                      integ_clamped;
	modport source (output valid, drive, integ_clamped, input ready);
	modport sink   (input valid, drive, integ_clamped, output ready);
endinterface

interface plic_cfg_if;
	import plic_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

[rtl/pid_leaky_integral_clamp.sv]
// pid_leaky_integral_clamp: fixed-point pid controller with a leaky, clamped integrator
// depends on plic_pkg and the channel interfaces in plic_ifs

// One step item (target, measured) gives one result item (drive, integ_clamped). Items are
// handled one at a time: a new item is taken only after the sequencer is back in idle, and
// the sequence is longer when the integral term clamps with a nonzero integral gain. It is
// made of two shift-add multiplier passes (one gain bit per cycle; the leak product and the
// P and D products share the first pass) and, on such a clamp, a restoring divider that
// rebuilds the accumulator one quotient bit per cycle. The result sits in an output register,
// so a stalled result only blocks the next item once that item's own result is ready.
// Configuration writes are always taken and must be made while idle.

module pid_leaky_integral_clamp (
	input  logic       clk,
	input  logic       arst_n,
	plic_in_if.sink    step,
	plic_out_if.source result,
	plic_cfg_if.sink   cfg
);
	import plic_pkg::*;

	localparam int LK_AW = ACC_W + 1;          // accumulator plus error
	localparam int LK_HW = LK_AW + 1;          // leak partial product, high part
	localparam int PD_HW = ERR_W + 2;          // p plus d partial product, high part
	localparam int IG_HW = ACC_W + 1;          // integral partial product, high part
	localparam int IT_W  = IG_HW + GAIN_W;     // integral term
	localparam int SUM_W = IT_W + 1;
	localparam int PD_W  = PD_HW + GAIN_W;

	// configuration registers
	logic [GAIN_W-1:0]     prop_gain_q, integ_gain_q, deriv_gain_q;
	logic [LIMIT_W-1:0]    integ_limit_q;
	logic [LEAK_W-1:0]     leak_factor_q;

	// controller state
	logic [ACC_W-1:0]      acc_q;
	logic [TGT_W-1:0]      prev_q;

	// sequencer
	state_t                state_q, state_d;
	logic [CNT_W-1:0]      cnt_q;
	logic                  take_item, out_load, mul_last, div_last;

	// serial multiplier operands and partial products
	logic [ERR_W-1:0]      err_q, dm_q;
	logic [GAIN_W-1:0]     pg_sr_q, dg_sr_q, ig_sr_q;
	logic [LEAK_W-1:0]     lk_sr_q;
	logic [LK_AW-1:0]      lk_a_q;
	logic [LK_HW-1:0]      lk_h_q;
	logic [LEAK_W-1:0]     lk_l_q;
	logic [PD_HW-1:0]      pd_h_q;
	logic [GAIN_W-1:0]     pd_l_q;
	logic [IG_HW-1:0]      ig_h_q;
	logic [GAIN_W-1:0]     ig_l_q;

	// clamp and divider
	logic [IT_W-1:0]       it_q;
	logic                  clamp_q, div_go_q, div_neg_q;
	logic [GAIN_W-1:0]     dv_q, rem_q;
	logic [DIV_STEPS-1:0]  quo_q;

	// output register
	logic                  out_valid_q;
	logic [DRIVE_W-1:0]    drive_q;
	logic                  clamp_out_q;

	// combinational datapath
	logic [ERR_W-1:0]      err_in, dm_in;
	logic [LK_AW-1:0]      lk_a_in, lk_add;
	logic [LK_HW:0]        lk_t;
	logic [PD_HW:0]        err_x, dm_x, pd_ta, pd_tb, pd_t;
	logic [IG_HW:0]        acc_x, ig_add, ig_t;
	logic [LK_HW:0]        lk_fl, lk_tz;
	logic [ACC_W-1:0]      lk_sat;
	logic [IT_W-1:0]       ip, bnd, nbnd;
	logic                  over, under;
	logic [SUM_W-1:0]      sm;
	logic                  sm_fits;
	logic [DRIVE_W-1:0]    drive_sat;
	logic [GAIN_W:0]       trial;
	logic [GAIN_W+1:0]     diff;
	logic                  ge;

	// configuration writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q   <= '0;
			integ_gain_q  <= '0;
			deriv_gain_q  <= '0;
			integ_limit_q <= {LIMIT_W{1'b1}};
			leak_factor_q <= LEAK_W'(1) << LEAK_FRAC;
		end else if (cfg.valid) begin
			unique case (reg_idx_t'(cfg.index))
				REG_PROP_GAIN:   prop_gain_q   <= cfg.data[GAIN_W-1:0];
				REG_INTEG_GAIN:  integ_gain_q  <= cfg.data[GAIN_W-1:0];
				REG_DERIV_GAIN:  deriv_gain_q  <= cfg.data[GAIN_W-1:0];
				REG_INTEG_LIMIT: integ_limit_q <= cfg.data[LIMIT_W-1:0];
				REG_LEAK_FACTOR: leak_factor_q <= cfg.data[LEAK_W-1:0];
				default: ;
			endcase
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign mul_last = (cnt_q == CNT_W'(MUL_STEPS - 1));
	assign div_last = (cnt_q == CNT_W'(DIV_STEPS - 1));

	// next state and handshakes
	always_comb begin
		state_d   = state_q;
		take_item = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				take_item = step.valid;
				if (step.valid) state_d = ST_MUL_LEAK;
			end
			ST_MUL_LEAK: begin
				if (mul_last) state_d = ST_LEAK_FIX;
			end
			ST_LEAK_FIX: state_d = ST_MUL_INTEG;
			ST_MUL_INTEG: begin
				if (mul_last) state_d = ST_CLAMP;
			end
			ST_CLAMP: state_d = ST_SUM;
			ST_SUM: begin
				out_load = !out_valid_q || result.ready;
				if (out_load) state_d = div_go_q ? ST_DIV : ST_IDLE;
			end
			ST_DIV: begin
				if (div_last) state_d = ST_DIV_FIX;
			end
			ST_DIV_FIX: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	assign step.ready = (state_q == ST_IDLE);

	// step arithmetic
	always_comb begin
		// error and measurement change
		err_in  = {step.target[TGT_W-1], step.target} - {step.measured[TGT_W-1], step.measured};
		dm_in   = {step.measured[TGT_W-1], step.measured} - {prev_q[TGT_W-1], prev_q};
		lk_a_in = {{(LK_AW-ERR_W){err_in[ERR_W-1]}}, err_in} + {acc_q[ACC_W-1], acc_q};

		// leak multiplier step, unsigned leak factor
		lk_add = lk_sr_q[0] ? lk_a_q : '0;
		lk_t   = {lk_h_q[LK_HW-1], lk_h_q} + {{(LK_HW+1-LK_AW){lk_add[LK_AW-1]}}, lk_add};

		// p and d multiplier step, sign bit of the gain weighs negative
		err_x = {{(PD_HW+1-ERR_W){err_q[ERR_W-1]}}, err_q};
		dm_x  = {{(PD_HW+1-ERR_W){dm_q[ERR_W-1]}}, dm_q};
		pd_ta = pg_sr_q[0] ? (mul_last ? -err_x : err_x) : '0;
		pd_tb = dg_sr_q[0] ? (mul_last ? -dm_x : dm_x) : '0;
		pd_t  = {pd_h_q[PD_HW-1], pd_h_q} + pd_ta + pd_tb;

		// integral multiplier step
		acc_x  = {{(IG_HW+1-ACC_W){acc_q[ACC_W-1]}}, acc_q};
		ig_add = ig_sr_q[0] ? (mul_last ? -acc_x : acc_x) : '0;
		ig_t   = {ig_h_q[IG_HW-1], ig_h_q} + ig_add;

		// leak product shifted right with truncation toward zero, then saturated
		lk_fl = {lk_h_q, lk_l_q[LEAK_FRAC]};
		lk_tz = lk_fl + {{LK_HW{1'b0}}, lk_h_q[LK_HW-1] & (|lk_l_q[LEAK_FRAC-1:0])};
		if ((&lk_tz[LK_HW:ACC_W-1]) || !(|lk_tz[LK_HW:ACC_W-1])) begin
			lk_sat = lk_tz[ACC_W-1:0];
		end else if (lk_tz[LK_HW]) begin
			lk_sat = {1'b1, {(ACC_W-1){1'b0}}};
		end else begin
			lk_sat = {1'b0, {(ACC_W-1){1'b1}}};
		end

		// integral term against the limit
		ip    = {ig_h_q, ig_l_q};
		bnd   = {{(IT_W-LIMIT_W-FRAC_W){1'b0}}, integ_limit_q, {FRAC_W{1'b0}}};
		nbnd  = -bnd;
		over  = $signed(ip) > $signed(bnd);
		under = $signed(ip) < $signed(nbnd);

		// term sum, floored and saturated to the drive width
		sm = {it_q[IT_W-1], it_q} + {{(SUM_W-PD_W){pd_h_q[PD_HW-1]}}, pd_h_q, pd_l_q};
		sm_fits = (&sm[SUM_W-1:DRIVE_W+FRAC_W-1]) || !(|sm[SUM_W-1:DRIVE_W+FRAC_W-1]);
		if (sm_fits) begin
			drive_sat = sm[DRIVE_W+FRAC_W-1:FRAC_W];
		end else if (sm[SUM_W-1]) begin
			drive_sat = {1'b1, {(DRIVE_W-1){1'b0}}};
		end else begin
			drive_sat = {1'b0, {(DRIVE_W-1){1'b1}}};
		end

		// restoring divider step
		trial = {rem_q, quo_q[DIV_STEPS-1]};
		diff  = {1'b0, trial} - {2'b00, dv_q};
		ge    = !diff[GAIN_W+1];
	end

	// datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			prev_q      <= '0;
			cnt_q       <= '0;
			err_q       <= '0;
			dm_q        <= '0;
			pg_sr_q     <= '0;
			dg_sr_q     <= '0;
			ig_sr_q     <= '0;
			lk_sr_q     <= '0;
			lk_a_q      <= '0;
			lk_h_q      <= '0;
			lk_l_q      <= '0;
			pd_h_q      <= '0;
			pd_l_q      <= '0;
			ig_h_q      <= '0;
			ig_l_q      <= '0;
			it_q        <= '0;
			clamp_q     <= 1'b0;
			div_go_q    <= 1'b0;
			div_neg_q   <= 1'b0;
			dv_q        <= '0;
			rem_q       <= '0;
			quo_q       <= '0;
			out_valid_q <= 1'b0;
			drive_q     <= '0;
			clamp_out_q <= 1'b0;
		end else begin
			// result handoff
			if (out_load) begin
				out_valid_q <= 1'b1;
				drive_q     <= drive_sat;
				clamp_out_q <= clamp_q;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					// capture the item and load the gain shift registers
					if (take_item) begin
						err_q   <= err_in;
						dm_q    <= dm_in;
						prev_q  <= step.measured;
						lk_a_q  <= lk_a_in;
						pg_sr_q <= prop_gain_q;
						dg_sr_q <= deriv_gain_q;
						ig_sr_q <= integ_gain_q;
						lk_sr_q <= leak_factor_q;
						lk_h_q  <= '0;
						pd_h_q  <= '0;
						ig_h_q  <= '0;
						cnt_q   <= '0;
					end
				end
				ST_MUL_LEAK: begin
					// one leak bit and one p and d gain bit per cycle
					lk_h_q  <= lk_t[LK_HW:1];
					lk_l_q  <= {lk_t[0], lk_l_q[LEAK_W-1:1]};
					lk_sr_q <= lk_sr_q >> 1;
					pd_h_q  <= pd_t[PD_HW:1];
					pd_l_q  <= {pd_t[0], pd_l_q[GAIN_W-1:1]};
					pg_sr_q <= pg_sr_q >> 1;
					dg_sr_q <= dg_sr_q >> 1;
					cnt_q   <= mul_last ? '0 : cnt_q + 1'b1;
				end
				ST_LEAK_FIX: begin
					acc_q <= lk_sat;
				end
				ST_MUL_INTEG: begin
					ig_h_q  <= ig_t[IG_HW:1];
					ig_l_q  <= {ig_t[0], ig_l_q[GAIN_W-1:1]};
					ig_sr_q <= ig_sr_q >> 1;
					cnt_q   <= mul_last ? '0 : cnt_q + 1'b1;
				end
				ST_CLAMP: begin
					// clamp and set up the back division of the bound by the gain
					it_q      <= over ? bnd : (under ? nbnd : ip);
					clamp_q   <= over || under;
					div_go_q  <= (over || under) && (|integ_gain_q);
					div_neg_q <= under ^ integ_gain_q[GAIN_W-1];
					dv_q      <= integ_gain_q[GAIN_W-1] ? -integ_gain_q : integ_gain_q;
					quo_q     <= {integ_limit_q, {FRAC_W{1'b0}}};
					rem_q     <= '0;
					cnt_q     <= '0;
				end
				ST_DIV: begin
					rem_q <= ge ? diff[GAIN_W-1:0] : trial[GAIN_W-1:0];
					quo_q <= {quo_q[DIV_STEPS-2:0], ge};
					cnt_q <= div_last ? '0 : cnt_q + 1'b1;
				end
				ST_DIV_FIX: begin
					// signed quotient, truncated toward zero
					acc_q <= div_neg_q ? -{{(ACC_W-DIV_STEPS){1'b0}}, quo_q}
					                   : {{(ACC_W-DIV_STEPS){1'b0}}, quo_q};
				end
				default: ;
			endcase
		end
	end

	// result channel
	assign result.valid         = out_valid_q;
	assign result.drive         = drive_q;
	assign result.integ_clamped = clamp_out_q;

endmodule

[bench/pid_leaky_integral_clamp_tb.sv]
// pid_leaky_integral_clamp_tb: self-checking bench for the leaky, clamped pid controller
// drives steps and register writes, predicts every result item and compares it field by field
// depends on plic_pkg, the channel interfaces in plic_ifs and pid_leaky_integral_clamp

module pid_leaky_integral_clamp_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import plic_pkg::*;

	localparam longint ACC_HI      = 64'sd549755813887;
	localparam longint ACC_LO      = -64'sd549755813888;
	localparam longint DRIVE_HI    = 64'sd2147483647;
	localparam longint DRIVE_LO    = -64'sd2147483648;
	localparam int     SETTLE_CYCLES = 90;
	localparam int     RECV_HOLD   = 500;
	localparam int     CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic signed [TGT_W-1:0] target;
		logic signed [TGT_W-1:0] measured;
	} step_item_t;

	typedef struct packed {
		logic signed [DRIVE_W-1:0] drive;
		logic                      clamped;
	} drive_item_t;

	logic clk;
	logic arst_n;

	plic_in_if  step_ch();
	plic_out_if result_ch();
	plic_cfg_if cfg_ch();

	pid_leaky_integral_clamp uut (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// pending steps and predicted drive values
	step_item_t  step_queue[$];
	drive_item_t drive_expect[$];

	// shadow copy of the controller registers and loop state
	longint kp = 0;
	longint ki = 0;
	longint kd = 0;
	longint i_limit = 64'sd2147483647;
	longint leak = 32768;
	longint integ_acc = 0;
	longint last_meas = 0;

	int send_idle = 0;
	int recv_idle = 0;
	int hold_req = 0;
	int hold_ack = 0;
	int hold_left = 0;
	logic step_took = 1'b0;
	logic signed [TGT_W-1:0] hold_tgt = '0;

	int fail_count = 0;
	int steps_taken = 0;
	int results_seen = 0;
	int clamp_hits = 0;
	int drive_sats = 0;
	int settings_used = 0;
	int cycles = 0;

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still expected", cycles,
				drive_expect.size());
			$display("FAIL");
			$finish;
		end
	end

	function automatic longint clip_acc(input longint v);
		if (v > ACC_HI)
			return ACC_HI;
		if (v < ACC_LO)
			return ACC_LO;
		return v;
	endfunction

	// one control step: leak the integrator, clamp the i term, sum and saturate
	task automatic advance_loop(input logic signed [TGT_W-1:0] tgt,
			input logic signed [TGT_W-1:0] meas, output drive_item_t res);
		longint err, p_term, d_term, i_term, bound, total, scaled;
		err = longint'(tgt) - longint'(meas);
		p_term = err * kp;
		d_term = (longint'(meas) - last_meas) * kd;
		bound = i_limit * 256;
		// signed division truncates toward zero, as the leak requires
		integ_acc = clip_acc(((integ_acc + err) * leak) / 32768);
		i_term = integ_acc * ki;
		last_meas = longint'(meas);
		res.clamped = 1'b0;
		if (i_term > bound) begin
			i_term = bound;
			res.clamped = 1'b1;
		end else if (i_term < -bound) begin
			i_term = -bound;
			res.clamped = 1'b1;
		end
		// rebuild the integrator from the clamped term
		if (res.clamped && ki != 0)
			integ_acc = clip_acc(i_term / ki);
		total = p_term + i_term + d_term;
		scaled = total >>> FRAC_W;
		if (scaled > DRIVE_HI)
			scaled = DRIVE_HI;
		if (scaled < DRIVE_LO)
			scaled = DRIVE_LO;
		res.drive = scaled[DRIVE_W-1:0];
	endtask

	// step driver: holds an item until it is taken, random gaps between items
	always @(negedge clk) begin
		step_item_t nxt;
		if (!step_ch.valid || step_took) begin
			if (arst_n && step_queue.size() != 0 && $urandom_range(99) >= send_idle) begin
				nxt = step_queue.pop_front();
				step_ch.valid    <= 1'b1;
				step_ch.target   <= nxt.target;
				step_ch.measured <= nxt.measured;
			end else begin
				step_ch.valid <= 1'b0;
			end
		end
	end

	// result receiver: random stalls, plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_left <= RECV_HOLD;
			result_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// monitor: predict on each taken step, check each taken result
	always @(posedge clk) begin
		drive_item_t want;
		step_took <= step_ch.valid && step_ch.ready;
		if (arst_n && step_ch.valid && step_ch.ready) begin
			advance_loop(step_ch.target, step_ch.measured, want);
			drive_expect.push_back(want);
			steps_taken++;
			if (want.clamped)
				clamp_hits++;
			if (longint'(want.drive) == DRIVE_HI || longint'(want.drive) == DRIVE_LO)
				drive_sats++;
		end
		if (arst_n && result_ch.valid && result_ch.ready) begin
			results_seen++;
			if (drive_expect.size() == 0) begin
				$display("%0t: unexpected result item, drive %0d clamped %0b", $time,
					result_ch.drive, result_ch.integ_clamped);
				fail_count++;
			end else begin
				want = drive_expect.pop_front();
				if (result_ch.drive !== want.drive) begin
					$display("%0t: drive expected %0d got %0d", $time, want.drive,
						result_ch.drive);
					fail_count++;
				end
				if (result_ch.integ_clamped !== want.clamped) begin
					$display("%0t: integ_clamped expected %0b got %0b", $time, want.clamped,
						result_ch.integ_clamped);
					fail_count++;
				end
			end
		end
	end

	// single register write, shadow updated once the write is taken
	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] word);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= word;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			REG_PROP_GAIN:   kp = longint'($signed(word[GAIN_W-1:0]));
			REG_INTEG_GAIN:  ki = longint'($signed(word[GAIN_W-1:0]));
			REG_DERIV_GAIN:  kd = longint'($signed(word[GAIN_W-1:0]));
			REG_INTEG_LIMIT: i_limit = longint'(word[LIMIT_W-1:0]);
			REG_LEAK_FACTOR: leak = longint'(word[LEAK_W-1:0]);
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// full register set; unused upper data bits of the narrow registers carry junk
	task automatic load_settings(input logic [GAIN_W-1:0] pg, input logic [GAIN_W-1:0] ig,
			input logic [GAIN_W-1:0] dg, input logic [LIMIT_W-1:0] lim,
			input logic [LEAK_W-1:0] lf);
		write_reg(REG_PROP_GAIN, {15'($urandom), pg});
		write_reg(REG_INTEG_GAIN, {15'($urandom), ig});
		write_reg(REG_DERIV_GAIN, {15'($urandom), dg});
		write_reg(REG_INTEG_LIMIT, lim);
		write_reg(REG_LEAK_FACTOR, {15'($urandom), lf});
		settings_used++;
	endtask

	// wait until every step is taken and every result is back, then let the block go idle
	task automatic settle();
		while (step_queue.size() != 0 || step_ch.valid || drive_expect.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic queue_step(input logic signed [TGT_W-1:0] t,
			input logic signed [TGT_W-1:0] m);
		step_item_t it;
		it.target = t;
		it.measured = m;
		step_queue.push_back(it);
	endtask

	function automatic logic [TGT_W-1:0] pick_edge();
		case ($urandom_range(3))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			default: return 16'hFFFF;
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain();
		case ($urandom_range(3))
			0: return 16'($urandom);
			1: return 16'($urandom_range(2048)) - 16'd1024;
			2: return 16'($urandom_range(512));
			default: begin
				case ($urandom_range(3))
					0: return 16'h8000;
					1: return 16'h7FFF;
					2: return 16'h0000;
					default: return 16'h0100;
				endcase
			end
		endcase
	endfunction

	function automatic logic [LIMIT_W-1:0] pick_limit();
		case ($urandom_range(2))
			0: return 31'($urandom_range(2000));
			1: return 31'($urandom);
			default: begin
				case ($urandom_range(2))
					0: return 31'd0;
					1: return 31'd1;
					default: return 31'h7FFF_FFFF;
				endcase
			end
		endcase
	endfunction

	function automatic logic [LEAK_W-1:0] pick_leak();
		case ($urandom_range(3))
			0, 1: return 16'($urandom_range(32768, 30000));
			2: return 16'($urandom);
			default: begin
				case ($urandom_range(3))
					0: return 16'd0;
					1: return 16'd32767;
					2: return 16'd32768;
					default: return 16'hFFFF;
				endcase
			end
		endcase
	endfunction

	// random steps: half a loop tracking a held setpoint, the rest wide jumps and edge values
	task automatic queue_random(input int count);
		logic signed [TGT_W-1:0] t, m;
		int kind;
		for (int n = 0; n < count; n++) begin
			kind = $urandom_range(99);
			if (kind < 35) begin
				t = 16'($urandom);
				m = 16'($urandom);
			end else if (kind < 85) begin
				if ($urandom_range(15) == 0)
					hold_tgt = 16'($urandom);
				t = hold_tgt;
				m = t + 16'($urandom_range(64)) - 16'd32;
			end else begin
				t = pick_edge();
				m = pick_edge();
			end
			queue_step(t, m);
		end
	endtask

	// stimulus sequence
	initial begin
		arst_n = 1'b0;
		step_ch.valid = 1'b0;
		step_ch.target = '0;
		step_ch.measured = '0;
		result_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_PROP_GAIN;
		cfg_ch.data = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle = 38;
		recv_idle = 63;

		// reset values: all gains zero, so drive stays zero
		queue_step(16'sd100, -16'sd50);
		queue_step(16'h8000, 16'h7FFF);
		settle();

		// unity p, clamps both ways on full-scale error, derivative on measurement swings
		load_settings(16'h0100, 16'h0100, 16'hFF80, 31'd100, 16'd32768);
		queue_step(16'h7FFF, 16'h8000);
		queue_step(16'h8000, 16'h7FFF);
		queue_step(16'sd0, 16'sd0);
		queue_step(16'sd5, 16'sd3);
		queue_step(16'sd5, 16'sd4);
		queue_step(16'sd5, 16'sd5);
		queue_step(16'h7FFF, 16'h7FFF);
		queue_step(16'h8000, 16'h8000);
		settle();

		// leak above one with full gains: integrator grows until it clamps, drive saturates
		load_settings(16'h7FFF, 16'h7FFF, 16'h7FFF, 31'h7FFF_FFFF, 16'hFFFF);
		repeat (8) queue_step(16'h7FFF, 16'h8000);
		repeat (2) queue_step(16'h8000, 16'h7FFF);
		settle();

		// zero integral gain with zero limit: never clamps; most negative p gain, no leak path
		load_settings(16'h8000, 16'h0000, 16'h0000, 31'd0, 16'd0);
		queue_step(16'h8000, 16'h7FFF);
		queue_step(16'h7FFF, 16'h8000);
		settle();

		// zero limit with nonzero gain: every nonzero integrator clamps; floor of small sums
		load_settings(16'h0001, 16'h8000, 16'h0000, 31'd0, 16'd32768);
		queue_step(16'sd1, 16'sd0);
		queue_step(-16'sd1, 16'sd0);
		queue_step(16'sd0, 16'sd0);
		settle();

		// random phases under three idle patterns
		for (int ph = 0; ph < 7; ph++) begin
			send_idle = (ph < 2) ? 38 : (ph < 4) ? 63 : 0;
			recv_idle = (ph < 2) ? 63 : (ph < 4) ? 38 : 0;
			if (ph == 6)
				load_settings(pick_gain(), 16'h0001, pick_gain(), 31'h7FFF_FFFF, 16'hFFFF);
			else
				load_settings(pick_gain(), pick_gain(), pick_gain(), pick_limit(), pick_leak());
			// long receiver hold-off while the sender keeps offering
			if (ph == 4)
				hold_req++;
			if (ph == 5) begin
				queue_random(100);
				settle();
				queue_random(100);
			end else begin
				queue_random(200);
			end
			settle();
		end

		if (drive_expect.size() != 0)
			fail_count++;
		$display("covered %0d steps under %0d register settings, %0d results checked",
			steps_taken, settings_used, results_seen);
		$display("integral clamps %0d, saturated drives %0d, mismatches %0d",
			clamp_hits, drive_sats, fail_count);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

[files.f]
rtl/plic_pkg.sv
rtl/plic_ifs.sv
rtl/pid_leaky_integral_clamp.sv
bench/pid_leaky_integral_clamp_tb.sv
